/* design/brf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants of the byte ring FIFO with rewind
// Operation codes, result status codes, the beat payload structs and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package brf_pkg;

  // Width of the capacity register, the count field and the fill level.
  localparam int unsigned CNT_W = 11;

  // Capacity after reset.
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [2:0] {
    OP_PUSH      = 3'd0,
    OP_BURST     = 3'd1,
    OP_POP       = 3'd2,
    OP_FLUSH     = 3'd3,
    OP_PUSH_BACK = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [7:0]       data_byte;
    logic             burst_first;
    logic [CNT_W-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       read_byte;
    logic [1:0]       status;
    logic             last;
    logic [CNT_W-1:0] fill_level;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic exec;      // run the held item, giving its first result
    logic pop_next;  // give the next byte of a multi-byte pop
    logic release_item;  // the held item is finished
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic item_valid;  // an item is held
    logic slot_free;   // the output register can take a result this cycle
    logic multi;       // the held item is a pop of more than one byte
    logic pop_last;    // the next pop byte is the final one
  } ctl_stat_t;

  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_POP  = 1'b1
  } ctl_state_e;

endpackage

/* design/brf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ctrl: sequencing controller
// Starts each held item and walks a multi-byte pop through its bytes,
// one byte per free output slot.
// ----------------------------------------------------------------------------
module brf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brf_pkg::ctl_stat_t  stat_i,
  output brf_pkg::ctl_cmd_t   cmd_o
);

  brf_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brf_pkg::CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brf_pkg::CTL_IDLE: begin
        if (stat_i.item_valid && stat_i.slot_free && stat_i.multi) begin
          state_d = brf_pkg::CTL_POP;
        end
      end
      brf_pkg::CTL_POP: begin
        if (stat_i.slot_free && stat_i.pop_last) begin
          state_d = brf_pkg::CTL_IDLE;
        end
      end
      default: state_d = brf_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      brf_pkg::CTL_IDLE: begin
        if (stat_i.item_valid && stat_i.slot_free) begin
          cmd_o.exec         = 1'b1;
          cmd_o.release_item = !stat_i.multi;
        end
      end
      brf_pkg::CTL_POP: begin
        if (stat_i.slot_free) begin
          cmd_o.pop_next     = 1'b1;
          cmd_o.release_item = stat_i.pop_last;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

/* design/brf_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_dpath: FIFO datapath
// Input holding register, capacity register, byte store, pointers, fill
// count, burst tracking and the output register.
// ----------------------------------------------------------------------------
module brf_dpath #(
  parameter int unsigned DEPTH   = 1024,
  parameter int unsigned MAX_POP = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brf_pkg::CNT_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  brf_pkg::in_item_t             in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output brf_pkg::out_item_t            out_o,
  input  brf_pkg::ctl_cmd_t             cmd_i,
  output brf_pkg::ctl_stat_t            stat_o
);

  localparam int unsigned CW     = brf_pkg::CNT_W;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CmpW   = ((AW > CW) ? AW : CW) + 1;
  localparam int unsigned PopW   = $clog2(MAX_POP + 1);
  localparam int unsigned CapMax = (DEPTH < 2047) ? DEPTH : 2047;

  // Pointer advance with wrap at the capacity.
  function automatic logic [AW-1:0] ptr_adv(input logic [AW-1:0] ptr,
                                            input logic [CW-1:0] cap);
    logic [CmpW-1:0] nx;
    nx = CmpW'(ptr) + CmpW'(1);
    return (nx >= CmpW'(cap)) ? '0 : nx[AW-1:0];
  endfunction

  logic [7:0]          mem [DEPTH];
  logic [7:0]          rd_data_q;

  logic                in_full_q;
  brf_pkg::in_item_t   in_q;
  logic [CW-1:0]       cap_q;
  logic [AW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       brem_q, brem_d;
  logic                brej_q, brej_d;
  logic [PopW-1:0]     pop_left_q, pop_left_d;

  logic                out_valid_q;
  logic                out_pop_q;
  logic [1:0]          out_status_q;
  logic                out_last_q;
  logic [CW-1:0]       out_fill_q;

  logic [CW-1:0]       cap_eff;
  logic [CW-1:0]       room;
  logic [CW-1:0]       burst_len;
  logic [CW:0]         burst_need;
  logic [CW-1:0]       pop_sat;
  logic [CW-1:0]       pop_n;
  logic [CmpW-1:0]     rewind_ptr;
  logic                want_push;
  logic                mem_we;
  logic                rd_en;
  logic                emit;
  logic                slot_free;
  logic [1:0]          res_status;
  logic                res_last;
  logic                res_pop;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > CapMax) begin
      cap_eff = CW'(CapMax);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign room       = (cnt_q >= cap_eff) ? '0 : cap_eff - cnt_q;
  assign burst_len  = (in_q.count == '0) ? CW'(1) : in_q.count;
  assign burst_need = {1'b0, cnt_q} + {1'b0, burst_len};
  assign pop_sat    = (32'(in_q.count) > MAX_POP) ? CW'(MAX_POP) : in_q.count;
  assign pop_n      = (pop_sat > cnt_q) ? cnt_q : pop_sat;
  assign rewind_ptr = (CmpW'(rd_ptr_q) >= CmpW'(in_q.count)) ?
                      CmpW'(rd_ptr_q) - CmpW'(in_q.count) :
                      CmpW'(rd_ptr_q) + CmpW'(cap_eff) - CmpW'(in_q.count);

  assign slot_free  = !out_valid_q || out_ready_i;
  assign emit       = cmd_i.exec || cmd_i.pop_next;
  assign in_ready_o = !in_full_q || cmd_i.release_item;

  assign stat_o.item_valid = in_full_q;
  assign stat_o.slot_free  = slot_free;
  assign stat_o.multi      = (in_q.op == brf_pkg::OP_POP) && (pop_n > CW'(1));
  assign stat_o.pop_last   = (pop_left_q == PopW'(1));

  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    cnt_d      = cnt_q;
    brem_d     = brem_q;
    brej_d     = brej_q;
    pop_left_d = pop_left_q;
    want_push  = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    res_status = brf_pkg::ST_OK;
    res_last   = 1'b1;
    res_pop    = 1'b0;
    if (cmd_i.exec) begin
      unique case (in_q.op)
        brf_pkg::OP_PUSH: begin
          want_push = 1'b1;
        end
        brf_pkg::OP_BURST: begin
          if (in_q.burst_first) begin
            brem_d = burst_len - CW'(1);
            if (burst_need > {1'b0, cap_eff}) begin
              brej_d     = 1'b1;
              res_status = brf_pkg::ST_REJECT;
            end else begin
              brej_d    = 1'b0;
              want_push = 1'b1;
            end
          end else if (brem_q != '0) begin
            brem_d = brem_q - CW'(1);
            if (brej_q) begin
              res_status = brf_pkg::ST_REJECT;
            end else begin
              want_push = 1'b1;
            end
          end else begin
            want_push = 1'b1;
          end
        end
        brf_pkg::OP_POP: begin
          if (cnt_q == '0) begin
            res_status = brf_pkg::ST_EMPTY;
          end else if (pop_n != '0) begin
            rd_en      = 1'b1;
            res_pop    = 1'b1;
            rd_ptr_d   = ptr_adv(rd_ptr_q, cap_eff);
            cnt_d      = cnt_q - CW'(1);
            res_last   = (pop_n == CW'(1));
            pop_left_d = PopW'(pop_n - CW'(1));
          end
        end
        brf_pkg::OP_FLUSH: begin
          wr_ptr_d = '0;
          rd_ptr_d = '0;
          cnt_d    = '0;
          brem_d   = '0;
          brej_d   = 1'b0;
        end
        brf_pkg::OP_PUSH_BACK: begin
          if (in_q.count > room) begin
            res_status = brf_pkg::ST_REJECT;
          end else begin
            cnt_d    = cnt_q + in_q.count;
            rd_ptr_d = rewind_ptr[AW-1:0];
          end
        end
        default: ;  // unused codes change nothing
      endcase
      if (want_push) begin
        if (cnt_q >= cap_eff) begin
          res_status = brf_pkg::ST_REJECT;
        end else begin
          mem_we   = 1'b1;
          wr_ptr_d = ptr_adv(wr_ptr_q, cap_eff);
          cnt_d    = cnt_q + CW'(1);
        end
      end
    end else if (cmd_i.pop_next) begin
      rd_en      = 1'b1;
      res_pop    = 1'b1;
      rd_ptr_d   = ptr_adv(rd_ptr_q, cap_eff);
      cnt_d      = cnt_q - CW'(1);
      res_last   = (pop_left_q == PopW'(1));
      pop_left_d = pop_left_q - PopW'(1);
    end
  end

  // Byte store; the read lands straight in the output byte register.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_ptr_q] <= in_q.data_byte;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q   <= 1'b0;
      cap_q       <= brf_pkg::CAP_RESET;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      brem_q      <= '0;
      brej_q      <= 1'b0;
      pop_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_full_q <= 1'b1;
      end else if (cmd_i.release_item) begin
        in_full_q <= 1'b0;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
      brem_q     <= brem_d;
      brej_q     <= brej_d;
      pop_left_q <= pop_left_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
    if (emit) begin
      out_pop_q    <= res_pop;
      out_status_q <= res_status;
      out_last_q   <= res_last;
      out_fill_q   <= cnt_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_o.read_byte  = out_pop_q ? rd_data_q : 8'd0;
  assign out_o.status     = out_status_q;
  assign out_o.last       = out_last_q;
  assign out_o.fill_level = out_fill_q;

endmodule

/* design/byte_ring_fifo_with_rewind_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_rewind_unit: byte FIFO in a circular store
// Push, burst push, counted pop, flush and push back on a ring whose wrap
// point is the capacity register.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_we_i               cfg_wdata_i (capacity)
//   in       in         in_valid_i/in_ready_o  in_i (brf_pkg::in_item_t)
//   out      out        out_valid_o/out_ready_i out_o (brf_pkg::out_item_t)
//
// An accepted beat sits in a holding register and runs once the output
// register can take its result; that first result is registered there.
// A pop of n bytes gives n beats at one per cycle while out_ready_i stays
// high, each a registered read of the single-port byte store.
// The holding register takes the next item while a result waits.
// A low out_ready_i holds the output register and pauses a pop.
// Reset clears pointers, fill and burst state and sets the capacity to 1024;
// the store is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_rewind_unit #(
  parameter int unsigned DEPTH   = 1024,
  parameter int unsigned MAX_POP = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [brf_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  brf_pkg::in_item_t         in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output brf_pkg::out_item_t        out_o
);

  brf_pkg::ctl_cmd_t  cmd;
  brf_pkg::ctl_stat_t stat;

  brf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  brf_dpath #(
    .DEPTH   (DEPTH),
    .MAX_POP (MAX_POP)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

/* design/brf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_checker: port-level checks of the byte ring FIFO
// Watches the output channel of the top level and checks the result codes.
// ----------------------------------------------------------------------------
module brf_checker #(
  parameter int unsigned DEPTH = 1024
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input brf_pkg::out_item_t out_o
);

  // A stalled output beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output beat changed while stalled");

  // An empty answer is a lone beat with no byte and no fill.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == brf_pkg::ST_EMPTY |->
      out_o.last && out_o.read_byte == 8'd0 && out_o.fill_level == '0)
    else $error("empty status with bad companion fields");

  // Only pop bytes come before the final beat of an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.last |-> out_o.status == brf_pkg::ST_OK)
    else $error("non-final beat without ok status");

  // A rejected operation pops nothing and ends its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == brf_pkg::ST_REJECT |->
      out_o.last && out_o.read_byte == 8'd0)
    else $error("rejected beat carries a byte or is not final");

  // The fill never exceeds the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_o.fill_level) <= DEPTH)
    else $error("fill level beyond store depth");

endmodule

bind byte_ring_fifo_with_rewind_unit brf_checker #(
  .DEPTH (DEPTH)
) u_brf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
